// ----- src/ipcm_pkg.sv -----
// Shared types, codes and character helpers for the IP text CIDR matcher.
// No dependencies; imported by every module of the block.
`default_nettype none
package ipcm_pkg;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic [2:0] ST_MATCH    = 3'd0;
  localparam logic [2:0] ST_NOMATCH  = 3'd1;
  localparam logic [2:0] ST_PARSEERR = 3'd2;
  localparam logic [2:0] ST_FAMILY   = 3'd3;
  localparam logic [2:0] ST_BADLEN   = 3'd4;

  localparam logic [1:0] REG_RULE_IS_V6 = 2'd0;
  localparam logic [1:0] REG_RULE_HI    = 2'd1;
  localparam logic [1:0] REG_RULE_LO    = 2'd2;
  localparam logic [1:0] REG_PREFIX_LEN = 2'd3;

  localparam int OUT_BITS   = 133;
  localparam int OUT_TBYTES = 17;

  // Parser state; byte 0 of each byte vector sits in the top bits.
  typedef struct packed {
    logic [127:0] v6_bytes;
    logic [4:0]   write_pos;
    logic [4:0]   gap_pos;
    logic         gap_seen;
    logic [15:0]  group_value;
    logic         group_has_digit;
    logic         colon_seen;
    logic         flag_first;
    logic         flag_pend;
    logic         v4_tail_mode;
    logic [31:0]  v4_bytes;
    logic [2:0]   v4_octet_count;
    logic         v4_saw_digit;
    logic         v4_error;
    logic         v6_error;
  } ipcm_pstate_t;

  typedef struct packed {
    logic [63:0] addr_lo;
    logic [63:0] addr_hi;
    logic        addr_valid;
    logic        addr_is_v6;
    logic [2:0]  status;
  } ipcm_result_t;

  function automatic ipcm_pstate_t pstate_reset();
    ipcm_pstate_t s;
    s = '0;
    s.flag_first = 1'b1;
    return s;
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/ipcm_parser.sv -----
// Per-character parser: dotted-quad and hex-group state updated side by side.
// Depends on ipcm_pkg. Gives the state after the current character.
`default_nettype none
module ipcm_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            ch,
  input  wire logic                  last,
  output ipcm_pkg::ipcm_pstate_t     state_nxt
);
  import ipcm_pkg::*;

  ipcm_pstate_t st_r;

  logic [1:0]  v4_idx;
  logic [11:0] v4_nv;
  logic [4:0]  hx;
  logic        go;
  logic        is_digit;

  always_comb begin
    state_nxt = st_r;
    is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
    v4_idx    = st_r.v4_saw_digit ? 2'(st_r.v4_octet_count - 3'd1) : st_r.v4_octet_count[1:0];
    v4_nv     = 12'(st_r.v4_bytes[8*(3-v4_idx) +: 8]) * 12'd10 + 12'(ch[3:0]);
    hx        = hex_decode(ch);
    go        = 1'b1;

    if (ch == CH_COLON) state_nxt.colon_seen = 1'b1;

    // dotted-quad side
    if (ch == CH_COLON && !st_r.v4_tail_mode) begin
      state_nxt.v4_bytes       = '0;
      state_nxt.v4_octet_count = '0;
      state_nxt.v4_saw_digit   = 1'b0;
      state_nxt.v4_error       = 1'b0;
    end else if (!st_r.v4_error) begin
      if (is_digit) begin
        if (v4_nv > 12'd255) begin
          state_nxt.v4_error = 1'b1;
        end else if (!st_r.v4_saw_digit && st_r.v4_octet_count >= 3'd4) begin
          state_nxt.v4_error = 1'b1;
        end else begin
          if (!st_r.v4_saw_digit) begin
            state_nxt.v4_octet_count = st_r.v4_octet_count + 3'd1;
            state_nxt.v4_saw_digit   = 1'b1;
          end
          state_nxt.v4_bytes[8*(3-v4_idx) +: 8] = v4_nv[7:0];
        end
      end else if (ch == CH_DOT && st_r.v4_saw_digit) begin
        if (st_r.v4_octet_count == 3'd4) state_nxt.v4_error = 1'b1;
        else state_nxt.v4_saw_digit = 1'b0;
      end else begin
        state_nxt.v4_error = 1'b1;
      end
    end

    // hex-group side
    if (!st_r.v6_error) begin
      if (st_r.flag_first) begin
        state_nxt.flag_first = 1'b0;
        if (ch == CH_COLON) begin
          go = 1'b0;
          if (last) state_nxt.v6_error = 1'b1;
          else state_nxt.flag_pend = 1'b1;
        end
      end else if (st_r.flag_pend) begin
        state_nxt.flag_pend = 1'b0;
        if (ch != CH_COLON) begin
          state_nxt.v6_error = 1'b1;
          go = 1'b0;
        end
      end
      if (go) begin
        if (st_r.v4_tail_mode) begin
          if (ch == CH_COLON) state_nxt.v6_error = 1'b1;
        end else if (hx[4]) begin
          if (st_r.group_value[15:12] != 4'd0) begin
            state_nxt.v6_error = 1'b1;
          end else begin
            state_nxt.group_value     = {st_r.group_value[11:0], hx[3:0]};
            state_nxt.group_has_digit = 1'b1;
          end
        end else if (ch == CH_COLON) begin
          if (!st_r.group_has_digit) begin
            if (st_r.gap_seen) begin
              state_nxt.v6_error = 1'b1;
            end else begin
              state_nxt.gap_seen = 1'b1;
              state_nxt.gap_pos  = st_r.write_pos;
            end
          end else if (last || st_r.write_pos > 5'd14) begin
            state_nxt.v6_error = 1'b1;
          end else begin
            state_nxt.v6_bytes = st_r.v6_bytes |
                                 ({st_r.group_value, 112'd0} >> {st_r.write_pos, 3'b000});
            state_nxt.write_pos       = st_r.write_pos + 5'd2;
            state_nxt.group_value     = '0;
            state_nxt.group_has_digit = 1'b0;
          end
        end else if (ch == CH_DOT) begin
          if (st_r.write_pos <= 5'd12) state_nxt.v4_tail_mode = 1'b1;
          else state_nxt.v6_error = 1'b1;
        end else begin
          state_nxt.v6_error = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pstate_reset();
    end else if (accept) begin
      st_r <= last ? pstate_reset() : state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/ipcm_eval.sv -----
// End-of-string logic: gap expansion, family choice, prefix compare, status.
// Depends on ipcm_pkg. Purely combinational, fed from a registered snapshot.
`default_nettype none
module ipcm_eval (
  input  wire ipcm_pkg::ipcm_pstate_t snap,
  input  wire logic                   rule_is_v6,
  input  wire logic [63:0]            rule_addr_hi,
  input  wire logic [63:0]            rule_addr_lo,
  input  wire logic [7:0]             prefix_len,
  output ipcm_pkg::ipcm_result_t      res
);
  import ipcm_pkg::*;

  logic [127:0] a;
  logic [127:0] head;
  logic [127:0] tail;
  logic [127:0] addr6;
  logic [127:0] mask6;
  logic [31:0]  mask4;
  logic [4:0]   wp;
  logic [4:0]   n;
  logic         err6;
  logic         valid;
  logic         is6;
  logic         miss;

  always_comb begin
    a    = snap.v6_bytes;
    wp   = snap.write_pos;
    err6 = snap.v6_error;
    n    = '0;
    head = '0;
    tail = '0;
    if (!err6) begin
      if (snap.v4_tail_mode) begin
        if (snap.v4_error || snap.v4_octet_count != 3'd4 || wp > 5'd12) begin
          err6 = 1'b1;
        end else begin
          a  = a | ({snap.v4_bytes, 96'd0} >> {wp, 3'b000});
          wp = wp + 5'd4;
        end
      end else if (snap.group_has_digit) begin
        if (wp > 5'd14) begin
          err6 = 1'b1;
        end else begin
          a  = a | ({snap.group_value, 112'd0} >> {wp, 3'b000});
          wp = wp + 5'd2;
        end
      end
    end
    // expand '::': keep the head, move the groups after the gap to the end
    if (!err6 && snap.gap_seen) begin
      if (wp >= 5'd16 || snap.gap_pos > wp) begin
        err6 = 1'b1;
      end else begin
        n    = wp - snap.gap_pos;
        head = a & ~({128{1'b1}} >> {snap.gap_pos, 3'b000});
        tail = (a >> {5'(5'd16 - wp), 3'b000}) & ~({128{1'b1}} << {n, 3'b000});
        a    = head | tail;
        wp   = 5'd16;
      end
    end
    if (!err6 && wp != 5'd16) err6 = 1'b1;

    is6   = snap.colon_seen;
    valid = is6 ? !err6 : (!snap.v4_error && snap.v4_octet_count == 3'd4);
    addr6 = is6 ? (valid ? a : '0) : (valid ? {96'd0, snap.v4_bytes} : '0);

    mask6 = ~({128{1'b1}} >> prefix_len);
    mask4 = ~(32'hffff_ffff >> prefix_len[5:0]);
    miss  = is6 ? |((addr6 ^ {rule_addr_hi, rule_addr_lo}) & mask6)
                : |((addr6[31:0] ^ rule_addr_lo[31:0]) & mask4);

    if (prefix_len == 8'd0)                          res.status = ST_BADLEN;
    else if (is6 != rule_is_v6)                      res.status = ST_FAMILY;
    else if (prefix_len > (is6 ? 8'd128 : 8'd32))    res.status = ST_BADLEN;
    else if (!valid)                                 res.status = ST_PARSEERR;
    else                                             res.status = miss ? ST_NOMATCH : ST_MATCH;

    res.addr_is_v6 = is6;
    res.addr_valid = valid;
    res.addr_hi    = addr6[127:64];
    res.addr_lo    = addr6[63:0];
  end

endmodule
`default_nettype wire

// ----- src/ip_text_cidr_matcher.sv -----
// The final state goes to the snapshot register, then the result to the output register.
// Throughput: one character per cycle unless a stalled output holds in_tready low;
// strings may follow one another with no gap. The parser updates per character; the
// end-of-string snapshot is then expanded and compared in one more registered stage.
// Reset (rst_n, synchronous): parser returns to its start state, rule registers clear to 0.
`default_nettype none
module ip_text_cidr_matcher (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] ch
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // [2:0] status, [3] addr_is_v6, [4] addr_valid,
                                        // [68:5] addr_hi, [132:69] addr_lo, rest zero
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [63:0]  cfg_wdata
);
  import ipcm_pkg::*;

  logic         rule_is_v6_r;
  logic [63:0]  rule_addr_hi_r;
  logic [63:0]  rule_addr_lo_r;
  logic [7:0]   prefix_len_r;

  ipcm_pstate_t state_nxt;
  ipcm_pstate_t snap_r;
  logic         snap_v_r;
  ipcm_result_t res;
  ipcm_result_t out_r;
  logic         out_v_r;
  logic         in_acc;
  logic         s2_adv;

  assign s2_adv    = !out_v_r || out_tready;
  assign in_tready = !snap_v_r || s2_adv;
  assign in_acc    = in_tvalid && in_tready;

  ipcm_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .ch        (in_tdata),
    .last      (in_tlast),
    .state_nxt (state_nxt)
  );

  ipcm_eval u_eval (
    .snap         (snap_r),
    .rule_is_v6   (rule_is_v6_r),
    .rule_addr_hi (rule_addr_hi_r),
    .rule_addr_lo (rule_addr_lo_r),
    .prefix_len   (prefix_len_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_is_v6_r   <= 1'b0;
      rule_addr_hi_r <= '0;
      rule_addr_lo_r <= '0;
      prefix_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RULE_IS_V6: rule_is_v6_r   <= cfg_wdata[0];
        REG_RULE_HI:    rule_addr_hi_r <= cfg_wdata;
        REG_RULE_LO:    rule_addr_lo_r <= cfg_wdata;
        REG_PREFIX_LEN: prefix_len_r   <= cfg_wdata[7:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_acc && in_tlast) snap_v_r <= 1'b1;
      else if (s2_adv)        snap_v_r <= 1'b0;
      if (s2_adv)             out_v_r  <= snap_v_r;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) snap_r <= state_nxt;
    if (s2_adv)             out_r  <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_r.addr_lo, out_r.addr_hi, out_r.addr_valid,
                       out_r.addr_is_v6, out_r.status};

`ifndef SYNTH
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.status <= ST_BADLEN)
    else $error("status code out of range");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.addr_valid |-> out_r.addr_hi == 64'd0 && out_r.addr_lo == 64'd0)
    else $error("invalid address carries nonzero bits");
  a_v4_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.addr_is_v6 |-> out_r.addr_hi == 64'd0)
    else $error("IPv4 result has upper bits set");
  a_last_snap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> snap_v_r)
    else $error("last character did not produce a snapshot");
`endif

endmodule
`default_nettype wire
